/* rtl/assert_macros.svh */
// assertion macros shared by the frame sync rtl
// no dependencies; included by modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// combinational invariant checked at every clock edge outside reset
`define LPFS_ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// next-cycle implication checked outside reset
`define LPFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/lpfs_pkg.sv */
// shared types and constants for the length prefixed frame sync block
// no dependencies
package lpfs_pkg;

  // header is length low, length high, opcode
  localparam logic [15:0] HEAD_LEN       = 16'd3;
  localparam logic [1:0]  FILL_FULL      = 2'd2;
  localparam int          NUM_OPCODES    = 5;
  localparam logic [15:0] MAX_LENGTH_RST = 16'd256;
  localparam int          QUEUE_DEPTH    = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OPCODE_A   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OPCODE_B   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OPCODE_C   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OPCODE_D   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OPCODE_E   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 3'd5;

  // one result word
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [7:0]  frame_opcode;
    logic [15:0] frame_length;
    logic [15:0] byte_index;
    logic        last_byte;
  } out_word_t;

endpackage

/* rtl/lpfs_front.sv */
// front end: header search over received bytes and tagging of payload bytes
// depends on lpfs_pkg and assert_macros.svh
`include "assert_macros.svh"

module lpfs_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 push,
  input  logic [7:0]                           rx_byte,
  input  logic                                 cfg_we,
  input  logic [lpfs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lpfs_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                 wr_en,
  output lpfs_pkg::out_word_t                  wr_word
);

  logic [7:0]  opc_r [lpfs_pkg::NUM_OPCODES];
  logic [15:0] max_len_r;

  logic [15:0] win_r, win_nxt;
  logic [1:0]  fill_r, fill_nxt;
  logic        in_pay_r, in_pay_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  op_r, op_nxt;

  logic        op_hit;
  logic        hdr_ok;
  logic        last;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lpfs_pkg::NUM_OPCODES; i++) begin
        opc_r[i] <= 8'h00;
      end
      max_len_r <= lpfs_pkg::MAX_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lpfs_pkg::CFG_OPCODE_A:   opc_r[0]  <= cfg_data[7:0];
        lpfs_pkg::CFG_OPCODE_B:   opc_r[1]  <= cfg_data[7:0];
        lpfs_pkg::CFG_OPCODE_C:   opc_r[2]  <= cfg_data[7:0];
        lpfs_pkg::CFG_OPCODE_D:   opc_r[3]  <= cfg_data[7:0];
        lpfs_pkg::CFG_OPCODE_E:   opc_r[4]  <= cfg_data[7:0];
        lpfs_pkg::CFG_MAX_LENGTH: max_len_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // opcode of a candidate header is the byte arriving now
  always_comb begin
    op_hit = 1'b0;
    for (int i = 0; i < lpfs_pkg::NUM_OPCODES; i++) begin
      if (opc_r[i] == rx_byte) op_hit = 1'b1;
    end
  end

  assign hdr_ok = (win_r >= lpfs_pkg::HEAD_LEN) && (win_r <= max_len_r) && op_hit;
  assign last   = (rem_r <= 16'd1);

  always_comb begin
    win_nxt    = win_r;
    fill_nxt   = fill_r;
    in_pay_nxt = in_pay_r;
    rem_nxt    = rem_r;
    pos_nxt    = pos_r;
    len_nxt    = len_r;
    op_nxt     = op_r;
    wr_en      = 1'b0;

    wr_word.payload_byte = rx_byte;
    wr_word.frame_opcode = op_r;
    wr_word.frame_length = len_r;
    wr_word.byte_index   = pos_r;
    wr_word.last_byte    = last;

    if (push) begin
      if (in_pay_r) begin
        wr_en   = 1'b1;
        pos_nxt = pos_r + 16'd1;
        if (last) begin
          rem_nxt    = 16'd0;
          in_pay_nxt = 1'b0;
          fill_nxt   = 2'd0;
          win_nxt    = 16'd0;
        end else begin
          rem_nxt = rem_r - 16'd1;
        end
      end else if (fill_r == 2'd0) begin
        win_nxt  = {8'h00, rx_byte};
        fill_nxt = 2'd1;
      end else if (fill_r == 2'd1) begin
        win_nxt  = {rx_byte, win_r[7:0]};
        fill_nxt = lpfs_pkg::FILL_FULL;
      end else if (hdr_ok) begin
        len_nxt    = win_r;
        op_nxt     = rx_byte;
        rem_nxt    = win_r - 16'd1;
        pos_nxt    = 16'd0;
        in_pay_nxt = 1'b1;
        fill_nxt   = 2'd0;
        win_nxt    = 16'd0;
      end else begin
        // slide by one byte
        win_nxt  = {rx_byte, win_r[15:8]};
        fill_nxt = lpfs_pkg::FILL_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r    <= 16'd0;
      fill_r   <= 2'd0;
      in_pay_r <= 1'b0;
      rem_r    <= 16'd0;
      pos_r    <= 16'd0;
      len_r    <= 16'd0;
      op_r     <= 8'h00;
    end else begin
      win_r    <= win_nxt;
      fill_r   <= fill_nxt;
      in_pay_r <= in_pay_nxt;
      rem_r    <= rem_nxt;
      pos_r    <= pos_nxt;
      len_r    <= len_nxt;
      op_r     <= op_nxt;
    end
  end

  `LPFS_ASSERT_ALWAYS(a_pay_has_rem, clk, rst_n, !in_pay_r || (rem_r != 16'd0))
  `LPFS_ASSERT_NEXT(a_last_ends_frame, clk, rst_n, push && in_pay_r && last,
                    !in_pay_r && (fill_r == 2'd0))

endmodule

/* rtl/lpfs_queue.sv */
// back end: short result queue between the header search and the receiver
// depends on lpfs_pkg and assert_macros.svh
`include "assert_macros.svh"

module lpfs_queue #(
  parameter int DEPTH = lpfs_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lpfs_pkg::out_word_t push_word,
  input  logic                pop,
  output logic                full,
  output logic                empty,
  output lpfs_pkg::out_word_t head_word
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  lpfs_pkg::out_word_t mem [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push_acc;
  logic             pop_acc;

  assign full      = (count_r == CNT_FULL);
  assign empty     = (count_r == '0);
  assign push_acc  = push && !full;
  assign pop_acc   = pop && !empty;
  assign head_word = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_acc) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_acc) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    priority if (push_acc && !pop_acc) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_acc && !push_acc) begin
      count_nxt = count_r - 1'b1;
    end else begin
      // both or neither: occupancy holds
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push_acc) begin
      mem[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `LPFS_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CNT_FULL)
  `LPFS_ASSERT_NEXT(a_pop_drains, clk, rst_n, pop_acc && !push_acc,
                    CNT_W'(count_r + 1'b1) == $past(count_r))

endmodule

/* rtl/length_prefixed_frame_sync_top.sv */
// top level of the length prefixed frame sync block
// depends on lpfs_pkg, lpfs_front and lpfs_queue
//
// usage:
// - input channel: a received serial byte is offered on in_rx_byte with
//   in_push; it is taken at a clock edge where in_push is high and in_full low
// - the block looks for a three byte header (length low, length high,
//   opcode); a header with length 3..max_length and a known opcode opens a
//   frame, anything else slides the search window by one byte
// - result channel: each payload byte of an open frame comes out as one word
//   with opcode, length, index and a last mark; the oldest word is on the
//   out_ ports while out_empty is low and leaves on an edge with out_pop high
// - config port: cfg_we writes cfg_data into register cfg_index (opcodes a..e
//   at 0..4, max_length at 5); write only while the block is idle
// - a payload word enters the queue at the edge that takes its byte
// - throughput: one byte per cycle; the header check is a handful of compares
//   in the front end; bytes are taken while words wait, until the queue fills
// - stall: when the receiver stops popping, the queue (QDEPTH words) fills
//   and in_full rises until a word is taken
// - reset: synchronous rst_n empties the queue, clears the search window and
//   frame state, and sets opcodes to 0 and max_length to 256
module length_prefixed_frame_sync_top #(
  parameter int QDEPTH = lpfs_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input byte channel
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [7:0]                      in_rx_byte,
  // result channel
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [7:0]                      out_payload_byte,
  output logic [7:0]                      out_frame_opcode,
  output logic [15:0]                     out_frame_length,
  output logic [15:0]                     out_byte_index,
  output logic                            out_last_byte,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [lpfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpfs_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic                q_full;
  logic                in_acc;
  logic                wr_en;
  lpfs_pkg::out_word_t wr_word;
  lpfs_pkg::out_word_t head_word;

  // a byte is taken only while the queue has room for its word
  assign in_full = q_full;
  assign in_acc  = in_push && !q_full;

  lpfs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc),
    .rx_byte   (in_rx_byte),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .wr_en     (wr_en),
    .wr_word   (wr_word)
  );

  lpfs_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (wr_en),
    .push_word (wr_word),
    .pop       (out_pop),
    .full      (q_full),
    .empty     (out_empty),
    .head_word (head_word)
  );

  assign out_payload_byte = head_word.payload_byte;
  assign out_frame_opcode = head_word.frame_opcode;
  assign out_frame_length = head_word.frame_length;
  assign out_byte_index   = head_word.byte_index;
  assign out_last_byte    = head_word.last_byte;

endmodule

/* verif/lpfs_payload_tracker_pkg.sv */
// expected payload word tracking for the length prefixed frame sync testbench
// depends on lpfs_pkg for the word layout, register indexes and header constants
`timescale 1ns / 100ps

package lpfs_payload_tracker_pkg;
  import lpfs_pkg::*;

  class payload_word_tracker;
    // register copies
    logic [7:0]  opcode_set [NUM_OPCODES];
    logic [15:0] max_len;
    // deframer state
    logic [23:0] window;
    logic [1:0]  fill;
    bit          in_frame;
    logic [15:0] bytes_left;
    logic [15:0] next_index;
    logic [15:0] frame_len;
    logic [7:0]  frame_op;
    // words still owed by the block, oldest first
    out_word_t   owed_words [$];
    int unsigned mismatches;

    function new();
      foreach (opcode_set[i]) opcode_set[i] = 8'h00;
      max_len    = MAX_LENGTH_RST;
      window     = '0;
      fill       = '0;
      in_frame   = 1'b0;
      bytes_left = '0;
      next_index = '0;
      frame_len  = '0;
      frame_op   = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_MAX_LENGTH) begin
        max_len = val;
      end else if (idx <= CFG_OPCODE_E) begin
        opcode_set[idx] = val[7:0];
      end
    endfunction

    function bit opcode_known(logic [7:0] op);
      foreach (opcode_set[i]) begin
        if (opcode_set[i] == op) return 1'b1;
      end
      return 1'b0;
    endfunction

    // advance the deframer by one accepted byte
    function void note_rx(logic [7:0] rx);
      out_word_t   w;
      logic [15:0] len;
      if (in_frame) begin
        w.payload_byte = rx;
        w.frame_opcode = frame_op;
        w.frame_length = frame_len;
        w.byte_index   = next_index;
        w.last_byte    = (bytes_left <= 16'd1);
        owed_words.push_back(w);
        next_index = next_index + 16'd1;
        if (w.last_byte) begin
          bytes_left = '0;
          in_frame   = 1'b0;
          fill       = '0;
          window     = '0;
        end else begin
          bytes_left = bytes_left - 16'd1;
        end
        return;
      end
      if (fill < FILL_FULL) begin
        window = window | ({16'h0000, rx} << (8 * fill));
        fill   = fill + 2'd1;
        return;
      end
      window = {rx, window[15:0]};
      len    = window[15:0];
      if (len >= HEAD_LEN && len <= max_len && opcode_known(window[23:16])) begin
        frame_len  = len;
        frame_op   = window[23:16];
        bytes_left = len - 16'd1;
        next_index = '0;
        in_frame   = 1'b1;
        fill       = '0;
        window     = '0;
      end else begin
        // slide by one byte
        window = window >> 8;
        fill   = FILL_FULL;
      end
    endfunction

    function int waiting_words();
      return owed_words.size();
    endfunction

    function void compare_field(string label, logic [15:0] want_v, logic [15:0] got_v);
      if (got_v !== want_v) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want_v, got_v);
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (owed_words.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, expected none, actual %h", $time, got);
        return;
      end
      want = owed_words.pop_front();
      compare_field("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
      compare_field("frame_opcode", 16'(want.frame_opcode), 16'(got.frame_opcode));
      compare_field("frame_length", want.frame_length, got.frame_length);
      compare_field("byte_index", want.byte_index, got.byte_index);
      compare_field("last_byte", 16'(want.last_byte), 16'(got.last_byte));
    endfunction
  endclass

endpackage

/* verif/length_prefixed_frame_sync_top_test.sv */
// self-checking testbench for length_prefixed_frame_sync_top
// depends on lpfs_pkg and lpfs_payload_tracker_pkg; drives bytes, checks payload words
// against a cycle-free deframer kept in the tracker class
`timescale 1ns / 100ps

module length_prefixed_frame_sync_top_test;
  import lpfs_pkg::*;
  import lpfs_payload_tracker_pkg::*;

  typedef logic [7:0] opcode_list_t [NUM_OPCODES];

  // run limits
  localparam int LIMIT_CYCLES    = 500000;
  localparam int SETTLE_CYCLES   = 4;     // extra wait after the owed words drain, as margin
  localparam int HOLD_OFF_CYCLES = 300;   // long receiver stall to fill the queue

  logic                  clk;
  logic                  rst_n;
  logic                  in_push;
  logic                  in_full;
  logic [7:0]            in_rx_byte;
  logic                  out_empty;
  logic                  out_pop;
  logic [7:0]            out_payload_byte;
  logic [7:0]            out_frame_opcode;
  logic [15:0]           out_frame_length;
  logic [15:0]           out_byte_index;
  logic                  out_last_byte;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  payload_word_tracker frame_words;

  // current register values, used to shape the stimulus
  opcode_list_t cur_ops;
  logic [15:0]  cur_max;

  // idle rates in percent for each side, changed between phases
  int send_gap_pct;
  int recv_gap_pct;
  int bytes_sent;
  int cycle_count;
  bit hold_off_req;

  length_prefixed_frame_sync_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_rx_byte       (in_rx_byte),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_payload_byte (out_payload_byte),
    .out_frame_opcode (out_frame_opcode),
    .out_frame_length (out_frame_length),
    .out_byte_index   (out_byte_index),
    .out_last_byte    (out_last_byte),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // receive side: sample a popped word at the rising edge, pick the next
  // pop at the falling edge; a hold-off request turns into a counted stall
  initial begin : pop_side
    int        stall_left;
    bit        hold_taken;
    out_word_t got;
    stall_left = 0;
    hold_taken = 1'b0;
    out_pop    = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        got.payload_byte = out_payload_byte;
        got.frame_opcode = out_frame_opcode;
        got.frame_length = out_frame_length;
        got.byte_index   = out_byte_index;
        got.last_byte    = out_last_byte;
        frame_words.check_word(got);
      end
      @(negedge clk);
      if (hold_off_req && !hold_taken) begin
        stall_left = HOLD_OFF_CYCLES;
        hold_taken = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(0, 99) >= recv_gap_pct);
      end
    end
  end

  // one register write, taken at the next rising edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    frame_words.write_reg(idx, val);
  endtask

  // all six registers; upper data bits of the opcode writes are junk on purpose
  task automatic program_regs(input opcode_list_t ops, input logic [15:0] limit);
    for (int i = 0; i < NUM_OPCODES; i++)
      write_reg(CFG_IDX_W'(CFG_OPCODE_A + i), {8'($urandom), ops[i]});
    write_reg(CFG_MAX_LENGTH, limit);
    @(negedge clk) cfg_we <= 1'b0;
    cur_ops = ops;
    cur_max = limit;
  endtask

  // offer one byte, with random gaps before it, and wait until it is taken
  task automatic push_byte(input logic [7:0] rx);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      @(negedge clk);
      in_push <= 1'b0;
    end
    @(negedge clk);
    in_push    <= 1'b1;
    in_rx_byte <= rx;
    @(posedge clk);
    while (in_full) @(posedge clk);
    frame_words.note_rx(rx);
    bytes_sent++;
  endtask

  task automatic send_header(input logic [15:0] len, input logic [7:0] op);
    push_byte(len[7:0]);
    push_byte(len[15:8]);
    push_byte(op);
  endtask

  // stop offering, let every owed word drain, then let the pipe settle
  task automatic settle();
    @(negedge clk) in_push <= 1'b0;
    while (frame_words.waiting_words() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // random traffic: mostly well-formed frames with random payload, the rest
  // noise bytes, short and oversize lengths, unknown opcodes (frames only without noise)
  task automatic run_traffic(input int budget, input bit allow_noise);
    int          stop_at;
    int          pick;
    int          frames;
    logic [15:0] len;
    logic [15:0] top;
    logic [7:0]  op;
    stop_at = bytes_sent + budget;
    frames  = 0;
    while (bytes_sent < stop_at) begin
      pick = allow_noise ? int'($urandom_range(0, 99)) : 0;
      op   = cur_ops[$urandom_range(0, NUM_OPCODES - 1)];
      top  = (cur_max < 16'd20) ? cur_max : 16'd20;
      // an occasional long frame, never the first of a phase since the
      // window may still hold leftover bytes
      if (frames > 0 && $urandom_range(0, 24) == 0)
        top = (cur_max < 16'd300) ? cur_max : 16'd300;
      len = 16'($urandom_range(3, top));
      if (pick < 72) begin
        send_header(len, op);
        repeat (int'(len) - 1) push_byte(8'($urandom));
        frames++;
      end else if (pick < 82) begin
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
      end else if (pick < 88) begin
        // length below the header size
        send_header(16'($urandom_range(0, 2)), op);
      end else if (pick < 94 && cur_max != 16'hFFFF) begin
        // length just past the limit up to the top of the field
        send_header(16'($urandom_range(int'(cur_max) + 1, 16'hFFFF)), op);
      end else begin
        // frame shape with a random, mostly unknown opcode
        send_header(len, 8'($urandom));
        repeat (int'(len) - 1) push_byte(8'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    logic [7:0]   directed [$];
    opcode_list_t ops;
    in_push      = 1'b0;
    in_rx_byte   = 8'h00;
    cfg_we       = 1'b0;
    cfg_index    = CFG_OPCODE_A;
    cfg_data     = '0;
    rst_n        = 1'b0;
    hold_off_req = 1'b0;
    send_gap_pct = 34;
    recv_gap_pct = 53;
    bytes_sent   = 0;
    frame_words  = new();
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // opcode b and e equal, c and d at the byte extremes
    program_regs('{8'h5A, 8'hA5, 8'h00, 8'hFF, 8'hA5}, 16'd256);

    // directed: minimum frame with payload extremes, zero and short lengths
    // sliding, a frame that resyncs on a shared opcode, an oversize length
    directed = '{8'h03, 8'h00, 8'hFF, 8'h00, 8'hFF,
                 8'h00, 8'h00, 8'h5A, 8'h02, 8'h00, 8'hA5,
                 8'h01, 8'h00, 8'h5A, 8'h04, 8'h00, 8'hA5,
                 8'h80, 8'h7F, 8'h01,
                 8'h02, 8'h01, 8'h5A};
    foreach (directed[i]) push_byte(directed[i]);
    run_traffic(300, 1'b1);
    settle();

    // all opcodes the same, widest limit; framed traffic only so a stray
    // header cannot open a huge frame
    program_regs('{5{8'h3C}}, 16'hFFFF);
    run_traffic(350, 1'b0);
    settle();

    // swap the idle rates
    send_gap_pct = 53;
    recv_gap_pct = 34;
    foreach (ops[i]) ops[i] = 8'($urandom);
    program_regs(ops, 16'd3);
    run_traffic(300, 1'b1);
    settle();

    // limit below the header size: no header can be accepted
    foreach (ops[i]) ops[i] = 8'($urandom);
    program_regs(ops, 16'd2);
    run_traffic(30, 1'b1);
    settle();

    // no idling on either side
    send_gap_pct = 0;
    recv_gap_pct = 0;
    foreach (ops[i]) ops[i] = 8'($urandom);
    program_regs(ops, 16'($urandom_range(3, 512)));
    run_traffic(300, 1'b1);
    settle();

    // receiver stalls for a long stretch while bytes keep coming
    foreach (ops[i]) ops[i] = 8'($urandom);
    program_regs(ops, 16'd600);
    hold_off_req = 1'b1;
    run_traffic(250, 1'b1);
    settle();

    if (frame_words.mismatches == 0 && frame_words.waiting_words() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
